// File: hw/rtl/b256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b256_pkg
// Shared types, constants and lookup functions of the BLAKE-256/224 engine.
// ----------------------------------------------------------------------------
package b256_pkg;

    // one message word as it travels from the front end to the back end
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } t_item;

    // compression request from the sequencer
    typedef struct packed {
        logic        start;
        logic [63:0] cnt;
    } t_cmp_req;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_ROUNDS     = 2'd0,
        REG_DIGEST_224 = 2'd1,
        REG_SALT_HIGH  = 2'd2,
        REG_SALT_LOW   = 2'd3
    } t_reg_idx;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam logic [7:0] ROUNDS_DEF = 8'd14;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] IV256 [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };
    localparam logic [31:0] IV224 [8] = '{
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };
    localparam logic [31:0] PI_W [16] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
        32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
        32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917
    };

    // message permutation, entry j of a row in nibble j
    localparam logic [63:0] PERM_ROWS [10] = '{
        64'hFEDCBA9876543210, 64'h357B20C16DF984AE, 64'h491763EADF250C8B,
        64'h8F04A562EBCD1397, 64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
        64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD, 64'h5A417D2C803B9EF6,
        64'h0DC3E9BF5167482A
    };

    function automatic logic [3:0] perm_at(input logic [3:0] row, input logic [3:0] pos);
        logic [63:0] r;
        r = PERM_ROWS[row];
        return r[{pos, 2'b00} +: 4];
    endfunction

endpackage

// File: hw/rtl/b256_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b256_front
// Input stage: takes stream words, clamps the byte count, queues them.
// ----------------------------------------------------------------------------
module b256_front import b256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] message_word, [34:32] valid_bytes
    input  logic        i_s_axis_tlast,   // final_word
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    // byte counts above four count as a full word
    always_comb begin
        n_item.word   = i_s_axis_tdata[31:0];
        n_item.nbytes = (i_s_axis_tdata[34] && (i_s_axis_tdata[33:32] != 2'b00)) ?
                        3'd4 : i_s_axis_tdata[34:32];
        n_item.last   = i_s_axis_tlast;
    end

    assign o_s_axis_tready = !r_valid || !i_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_valid && !i_full;
    assign o_item          = r_item;

    // holding register in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// File: hw/rtl/b256_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b256_fifo
// Short word queue between front end and sequencer.
// ----------------------------------------------------------------------------
module b256_fifo import b256_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// File: hw/rtl/b256_comp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b256_comp
// Compression unit: one half-G step per cycle on fixed state positions,
// rows rotated between steps to walk columns and diagonals.
// ----------------------------------------------------------------------------
module b256_comp import b256_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmp_req     i_req,
    input  logic [7:0]   i_rounds,
    input  logic [127:0] i_salt,
    input  logic [31:0]  i_chain [8],
    output logic [3:0]   o_rd_addr,
    input  logic [31:0]  i_rd_data,
    output logic         o_done,
    output logic [31:0]  o_chain [8]
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_FIN  = 3'b100
    } t_cst;

    t_cst        r_st;
    logic [31:0] r_v [16];
    logic [31:0] n_v [16];
    logic [3:0]  r_step;
    logic [3:0]  n_step;
    logic [3:0]  r_row;
    logic [3:0]  n_row;
    logic [7:0]  r_rnd;
    logic [31:0] r_pik;
    logic [31:0] salt_w [4];
    logic [7:0]  nr;
    logic        last_step;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign salt_w[0] = i_salt[127:96];
    assign salt_w[1] = i_salt[95:64];
    assign salt_w[2] = i_salt[63:32];
    assign salt_w[3] = i_salt[31:0];
    assign nr        = (i_rounds == 8'd0) ? ROUNDS_DEF : i_rounds;
    assign last_step = (r_step == 4'd15) && (r_rnd == nr - 8'd1);
    assign o_done    = (r_st == C_FIN);

    // step position of the next cycle, drives the read-ahead
    always_comb begin
        n_step = 4'd0;
        n_row  = 4'd0;
        if (r_st == C_RUN) begin
            n_step = r_step + 4'd1;
            n_row  = r_row;
            if (r_step == 4'd15) begin
                n_row = (r_row == 4'd9) ? 4'd0 : r_row + 4'd1;
            end
        end
    end

    assign o_rd_addr = perm_at(n_row, n_step);

    // half of a G function on positions 0, 4, 8, 12 plus row rotation
    always_comb begin
        logic [31:0] x, a1, b1, c1, d1;
        logic [31:0] t [16];
        logic [1:0]  k;
        logic [2:0]  g;
        x  = i_rd_data ^ r_pik;
        g  = r_step[3:1];
        a1 = r_v[0] + r_v[4] + x;
        if (!r_step[0]) begin
            d1 = ror(r_v[12] ^ a1, 16);
            c1 = r_v[8] + d1;
            b1 = ror(r_v[4] ^ c1, 12);
        end else begin
            d1 = ror(r_v[12] ^ a1, 8);
            c1 = r_v[8] + d1;
            b1 = ror(r_v[4] ^ c1, 7);
        end
        t = r_v;
        t[0]  = a1;
        t[4]  = b1;
        t[8]  = c1;
        t[12] = d1;
        for (int r = 0; r < 4; r++) begin
            if (!r_step[0]) begin
                k = 2'd0;
            end else if (g == 3'd3) begin
                k = 2'(r + 1);
            end else if (g == 3'd7) begin
                k = 2'(5 - r);
            end else begin
                k = 2'd1;
            end
            for (int i = 0; i < 4; i++) begin
                n_v[4*r + i] = t[4*r + 32'(2'(2'(i) + k))];
            end
        end
    end

    // sequencing of rounds and steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= C_IDLE;
            r_step <= 4'd0;
            r_row  <= 4'd0;
            r_rnd  <= 8'd0;
        end else begin
            case (r_st)
                C_IDLE: begin
                    r_step <= 4'd0;
                    r_row  <= 4'd0;
                    r_rnd  <= 8'd0;
                    if (i_req.start) begin
                        r_st <= C_RUN;
                    end
                end
                C_RUN: begin
                    r_step <= n_step;
                    r_row  <= n_row;
                    if (r_step == 4'd15) begin
                        r_rnd <= r_rnd + 8'd1;
                    end
                    if (last_step) begin
                        r_st <= C_FIN;
                    end
                end
                C_FIN: begin
                    r_st <= C_IDLE;
                end
                default: begin
                    r_st <= C_IDLE;
                end
            endcase
        end
    end

    // working state
    always_ff @(posedge i_clk) begin
        r_pik <= PI_W[perm_at(n_row, n_step ^ 4'd1)];
        if (r_st == C_IDLE && i_req.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= i_chain[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_v[8 + i] <= PI_W[i] ^ salt_w[i];
            end
            r_v[12] <= PI_W[4] ^ i_req.cnt[31:0];
            r_v[13] <= PI_W[5] ^ i_req.cnt[31:0];
            r_v[14] <= PI_W[6] ^ i_req.cnt[63:32];
            r_v[15] <= PI_W[7] ^ i_req.cnt[63:32];
        end else if (r_st == C_RUN) begin
            r_v <= n_v;
        end
    end

    // finalization into the new chaining value
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_chain[i] = i_chain[i] ^ r_v[i] ^ r_v[8 + i] ^ salt_w[i % 4];
        end
    end

endmodule

// File: hw/rtl/b256_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b256_back
// Sequencer: packs bytes into the block buffer, pads, runs compressions
// and sends the digest words.
// ----------------------------------------------------------------------------
module b256_back import b256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_d224,
    input  logic        i_restart,
    input  t_item       i_item,
    input  logic        i_empty,
    output logic        o_pop,
    output t_cmp_req    o_req,
    input  logic        i_done,
    input  logic [31:0] i_chain_new [8],
    output logic [31:0] o_chain [8],
    input  logic [3:0]  i_rd_addr,
    output logic [31:0] o_rd_data,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast    // last_of_digest
);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_BYTE = 7'b0000010,
        B_PAD  = 7'b0000100,
        B_LENH = 7'b0001000,
        B_LENL = 7'b0010000,
        B_COMP = 7'b0100000,
        B_OUT  = 7'b1000000
    } t_bst;

    t_bst        r_st;
    t_bst        r_ret;
    logic [31:0] r_word;
    logic [2:0]  r_nb;
    logic [2:0]  r_bi;
    logic        r_fin;
    logic [5:0]  r_fill;
    logic [63:0] r_cnt;
    logic        r_empty;
    logic        r_padfirst;
    logic        r_fint;
    logic [31:0] r_acc;
    logic [31:0] r_chain [8];
    logic [2:0]  r_oi;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic [2:0]  r_oidx;
    logic        r_olast;
    logic        r_start;
    logic [63:0] r_t;
    logic [31:0] r_rdata;
    logic [31:0] r_blk [16];

    logic [7:0]  put_b;
    logic [31:0] merged;
    logic        put_en;
    logic        mem_we;
    logic [3:0]  mem_wa;
    logic [31:0] mem_wd;
    logic        out_load;
    logic        out_last;

    assign o_pop    = (r_st == B_IDLE) && !i_empty && !i_restart;
    assign o_chain  = r_chain;
    assign o_rd_data = r_rdata;
    assign o_req.start = r_start;
    assign o_req.cnt   = r_t;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {5'd0, r_oidx, r_odata};
    assign o_m_axis_tlast  = r_olast;
    assign out_load = (r_st == B_OUT) && (!r_ovalid || i_m_axis_tready);
    assign out_last = (r_oi == (i_d224 ? 3'd6 : 3'd7));

    // byte to place this cycle
    always_comb begin
        put_en = ((r_st == B_BYTE) && (r_bi < r_nb)) || (r_st == B_PAD);
        if (r_st == B_PAD) begin
            put_b = r_padfirst ? PAD_BYTE : 8'h00;
        end else begin
            case (r_bi[1:0])
                2'd0:    put_b = r_word[31:24];
                2'd1:    put_b = r_word[23:16];
                2'd2:    put_b = r_word[15:8];
                default: put_b = r_word[7:0];
            endcase
        end
        merged = r_acc;
        case (r_fill[1:0])
            2'd0:    merged[31:24] = put_b;
            2'd1:    merged[23:16] = put_b;
            2'd2:    merged[15:8]  = put_b;
            default: merged[7:0]   = put_b;
        endcase
    end

    // block buffer write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_fill[5:2];
        mem_wd = merged;
        if (put_en && (r_fill[1:0] == 2'd3)) begin
            mem_we = 1'b1;
            if (r_fint && !i_d224 && (r_fill[5:2] == 4'd13)) begin
                mem_wd = merged ^ 32'h1;
            end
        end else if (r_st == B_LENH) begin
            mem_we = 1'b1;
            mem_wa = 4'd14;
            mem_wd = r_cnt[63:32];
        end else if (r_st == B_LENL) begin
            mem_we = 1'b1;
            mem_wa = 4'd15;
            mem_wd = r_cnt[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_blk[mem_wa] <= mem_wd;
        end
        r_rdata <= r_blk[i_rd_addr];
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= B_IDLE;
            r_ret      <= B_IDLE;
            r_fill     <= 6'd0;
            r_cnt      <= 64'd0;
            r_fint     <= 1'b0;
            r_padfirst <= 1'b0;
            r_empty    <= 1'b0;
            r_start    <= 1'b0;
            r_ovalid   <= 1'b0;
            r_oi       <= 3'd0;
            r_chain    <= IV256;
        end else begin
            if (put_en) begin
                r_acc <= merged;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                B_IDLE: begin
                    if (i_restart) begin
                        for (int i = 0; i < 8; i++) begin
                            r_chain[i] <= i_d224 ? IV224[i] : IV256[i];
                        end
                        r_fill  <= 6'd0;
                        r_cnt   <= 64'd0;
                    end else if (!i_empty) begin
                        r_word <= i_item.word;
                        r_nb   <= i_item.nbytes;
                        r_fin  <= i_item.last;
                        r_bi   <= 3'd0;
                        r_st   <= B_BYTE;
                    end
                end
                B_BYTE: begin
                    if (r_bi < r_nb) begin
                        r_bi <= r_bi + 3'd1;
                        if (r_fill == 6'd63) begin
                            r_fill  <= 6'd0;
                            r_cnt   <= r_cnt + 64'd512;
                            r_t     <= r_cnt + 64'd512;
                            r_start <= 1'b1;
                            r_ret   <= B_BYTE;
                            r_st    <= B_COMP;
                        end else begin
                            r_fill <= r_fill + 6'd1;
                        end
                    end else if (r_fin) begin
                        r_cnt      <= r_cnt + {55'd0, r_fill, 3'd0};
                        r_empty    <= (r_fill == 6'd0);
                        r_padfirst <= 1'b1;
                        r_fint     <= 1'b1;
                        r_st       <= B_PAD;
                    end else begin
                        r_st <= B_IDLE;
                    end
                end
                B_PAD: begin
                    r_padfirst <= 1'b0;
                    if (r_fill == 6'd55) begin
                        r_fill <= 6'd56;
                        r_st   <= B_LENH;
                    end else if (r_fill == 6'd63) begin
                        r_fill  <= 6'd0;
                        r_t     <= r_cnt;
                        r_empty <= 1'b1;
                        r_start <= 1'b1;
                        r_ret   <= B_PAD;
                        r_st    <= B_COMP;
                    end else begin
                        r_fill <= r_fill + 6'd1;
                    end
                end
                B_LENH: begin
                    r_st <= B_LENL;
                end
                B_LENL: begin
                    r_t     <= r_empty ? 64'd0 : r_cnt;
                    r_start <= 1'b1;
                    r_ret   <= B_OUT;
                    r_oi    <= 3'd0;
                    r_st    <= B_COMP;
                end
                B_COMP: begin
                    // start request lasts one cycle
                    r_start <= 1'b0;
                    if (i_done) begin
                        r_chain <= i_chain_new;
                        r_st    <= r_ret;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        r_oi     <= r_oi + 3'd1;
                        if (out_last) begin
                            for (int i = 0; i < 8; i++) begin
                                r_chain[i] <= i_d224 ? IV224[i] : IV256[i];
                            end
                            r_fill  <= 6'd0;
                            r_cnt   <= 64'd0;
                            r_fint  <= 1'b0;
                            r_st    <= B_IDLE;
                        end
                    end
                end
                default: begin
                    r_st <= B_IDLE;
                end
            endcase
        end
    end

    // digest word register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= r_chain[r_oi];
            r_oidx  <= r_oi;
            r_olast <= out_last;
        end
    end

endmodule

// File: hw/rtl/blake256_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blake256_hash_engine
// BLAKE-256/224 hash engine with stream input and digest output.
// ----------------------------------------------------------------------------
// Usage:
//   Message words enter on the s_axis channel, big-endian, valid_bytes in
//   tdata[34:32] and the end of message on tlast. After the last word the
//   digest leaves on m_axis, one word per beat with its index in
//   tdata[34:32], tlast on the last word (eight words, seven for 224).
//   Registers (APB, 64-bit data, 8-byte stride): rounds, digest_224,
//   salt_high, salt_low. Write them only while the engine is idle; a write
//   to digest_224 starts a new message.
// Operation:
//   A word is fetched from the queue, its valid bytes are placed in order and
//   the word is then closed. A full block is compressed by the single half-G
//   datapath, which does one half of a G function a cycle. The last word
//   adds padding, one or two compressions and the seven or eight digest words.
//   A four-entry word queue lets the input keep flowing while the back end
//   compresses. If the receiver stalls, the current digest word holds and
//   the engine waits; reset empties all queues and loads the 256 IV.
// ----------------------------------------------------------------------------
module blake256_hash_engine import b256_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [31:0] message_word, [34:32] valid_bytes
    input  logic        i_s_axis_tlast,   // final_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast,   // last_of_digest
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [7:0]  r_rounds;
    logic        r_d224;
    logic [63:0] r_salth;
    logic [63:0] r_saltl;
    logic        r_restart;
    logic        wr_en;

    logic        push;
    t_item       f_item;
    logic        full;
    logic        pop;
    t_item       q_item;
    logic        empty;
    t_cmp_req    req;
    logic        done;
    logic [31:0] chain [8];
    logic [31:0] chain_new [8];
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;

    // register file
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds  <= ROUNDS_DEF;
            r_d224    <= 1'b0;
            r_salth   <= 64'd0;
            r_saltl   <= 64'd0;
            r_restart <= 1'b0;
        end else begin
            r_restart <= wr_en && (paddr[4:3] == REG_DIGEST_224);
            if (wr_en) begin
                case (paddr[4:3])
                    REG_ROUNDS:     r_rounds <= pwdata[7:0];
                    REG_DIGEST_224: r_d224   <= pwdata[0];
                    REG_SALT_HIGH:  r_salth  <= pwdata;
                    REG_SALT_LOW:   r_saltl  <= pwdata;
                    default:        r_rounds <= r_rounds;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_ROUNDS:     prdata = {56'd0, r_rounds};
            REG_DIGEST_224: prdata = {63'd0, r_d224};
            REG_SALT_HIGH:  prdata = r_salth;
            REG_SALT_LOW:   prdata = r_saltl;
            default:        prdata = 64'd0;
        endcase
    end

    b256_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_full          (full),
        .o_push          (push),
        .o_item          (f_item)
    );

    b256_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (empty)
    );

    b256_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_d224          (r_d224),
        .i_restart       (r_restart),
        .i_item          (q_item),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_req           (req),
        .i_done          (done),
        .i_chain_new     (chain_new),
        .o_chain         (chain),
        .i_rd_addr       (rd_addr),
        .o_rd_data       (rd_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    b256_comp u_comp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rounds  (r_rounds),
        .i_salt    ({r_salth, r_saltl}),
        .i_chain   (chain),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_done    (done),
        .o_chain   (chain_new)
    );

endmodule

// File: hw/rtl/b256_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b256_chk
// Port-level checks for the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module b256_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        pready
);

    // stalled digest word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("digest word changed under stall");

    // last word sits at index six or seven
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            (o_m_axis_tdata[34:32] == 3'd6) || (o_m_axis_tdata[34:32] == 3'd7))
        else $error("last digest word at wrong index");

    // nothing is offered right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind blake256_hash_engine b256_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .pready          (pready)
);

// File: dv/blake256_hash_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blake256_hash_engine_tb
// Self-checking bench for the BLAKE-256/224 engine. Message words go in on
// the input stream under random idling. A digest predictor, written from the
// algorithm, computes the expected digest words of each message. Every
// output word is compared field by field with the oldest expected word.
// Registers are rewritten between phases while the engine is idle.
// ----------------------------------------------------------------------------
module blake256_hash_engine_tb;
    import b256_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } t_digest_word;

    // digest predictor and expected word store
    class digest_scoreboard;
        logic [7:0]   rounds_cfg;
        logic         d224_cfg;
        logic [63:0]  salt_hi_cfg, salt_lo_cfg;
        logic [31:0]  chain[8];
        logic [31:0]  blk[16];
        logic [31:0]  v[16];
        logic [6:0]   fill;
        logic [63:0]  bit_cnt;
        t_digest_word expected_words[$];
        int           mismatches;

        function void reset_state();
            rounds_cfg  = ROUNDS_DEF;
            d224_cfg    = 1'b0;
            salt_hi_cfg = '0;
            salt_lo_cfg = '0;
            mismatches  = 0;
            foreach (blk[i]) blk[i] = '0;
            restart_msg();
        endfunction

        function void restart_msg();
            foreach (chain[i]) chain[i] = d224_cfg ? IV224[i] : IV256[i];
            fill    = '0;
            bit_cnt = '0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [63:0] val);
            case (idx)
                REG_ROUNDS: rounds_cfg = val[7:0];
                REG_DIGEST_224: begin
                    d224_cfg = val[0];
                    restart_msg();
                end
                REG_SALT_HIGH: salt_hi_cfg = val;
                REG_SALT_LOW:  salt_lo_cfg = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function int sched(int row, int j);
            logic [63:0] r;
            r = PERM_ROWS[row];
            return int'(r[4*j +: 4]);
        endfunction

        function void g_half_pair(int a, int b, int c, int d, int x, int y);
            v[a] = v[a] + v[b] + (blk[x] ^ PI_W[y]);
            v[d] = rotr(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 12);
            v[a] = v[a] + v[b] + (blk[y] ^ PI_W[x]);
            v[d] = rotr(v[d] ^ v[a], 8);
            v[c] = v[c] + v[d];
            v[b] = rotr(v[b] ^ v[c], 7);
        endfunction

        function void compress(logic [63:0] t);
            logic [31:0] salt[4];
            int nr;
            int row;
            salt[0] = salt_hi_cfg[63:32];
            salt[1] = salt_hi_cfg[31:0];
            salt[2] = salt_lo_cfg[63:32];
            salt[3] = salt_lo_cfg[31:0];
            nr  = (rounds_cfg == 0) ? 14 : int'(rounds_cfg);
            row = 0;
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int i = 0; i < 4; i++) v[8+i] = PI_W[i] ^ salt[i];
            v[12] = PI_W[4] ^ t[31:0];
            v[13] = PI_W[5] ^ t[31:0];
            v[14] = PI_W[6] ^ t[63:32];
            v[15] = PI_W[7] ^ t[63:32];
            for (int r = 0; r < nr; r++) begin
                g_half_pair(0, 4, 8, 12, sched(row, 0), sched(row, 1));
                g_half_pair(1, 5, 9, 13, sched(row, 2), sched(row, 3));
                g_half_pair(2, 6, 10, 14, sched(row, 4), sched(row, 5));
                g_half_pair(3, 7, 11, 15, sched(row, 6), sched(row, 7));
                g_half_pair(0, 5, 10, 15, sched(row, 8), sched(row, 9));
                g_half_pair(1, 6, 11, 12, sched(row, 10), sched(row, 11));
                g_half_pair(2, 7, 8, 13, sched(row, 12), sched(row, 13));
                g_half_pair(3, 4, 9, 14, sched(row, 14), sched(row, 15));
                row = (row == 9) ? 0 : row + 1;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] ^ v[i] ^ v[8+i] ^ salt[i % 4];
        endfunction

        function void put_byte(logic [7:0] b);
            int w;
            int sh;
            w  = fill[5:2];
            sh = 24 - 8 * fill[1:0];
            blk[w] = (blk[w] & ~(32'hFF << sh)) | (32'(b) << sh);
            fill = fill + 7'd1;
        endfunction

        // pad, append length and run the closing compression(s)
        function void close_message();
            bit no_msg_bits;
            no_msg_bits = (fill == 0);
            bit_cnt = bit_cnt + 64'(fill) * 8;
            put_byte(PAD_BYTE);
            if (fill > 56) begin
                while (fill < 64) put_byte(8'h00);
                compress(bit_cnt);
                fill = '0;
                no_msg_bits = 1'b1;
            end
            while (fill < 56) put_byte(8'h00);
            if (!d224_cfg) blk[13] = blk[13] ^ 32'h1;
            blk[14] = bit_cnt[63:32];
            blk[15] = bit_cnt[31:0];
            compress(no_msg_bits ? 64'd0 : bit_cnt);
        endfunction

        // accepted message word
        function void note_word(logic [31:0] word, logic [2:0] nb, logic fin);
            int n;
            int cnt;
            t_digest_word e;
            n = (nb > 4) ? 4 : int'(nb);
            for (int i = 0; i < n; i++) begin
                put_byte(word[31 - 8*i -: 8]);
                if (fill >= 64) begin
                    bit_cnt = bit_cnt + 64'd512;
                    compress(bit_cnt);
                    fill = '0;
                end
            end
            if (fin) begin
                close_message();
                cnt = d224_cfg ? 7 : 8;
                for (int i = 0; i < cnt; i++) begin
                    e.digest_word    = chain[i];
                    e.word_index     = 3'(i);
                    e.last_of_digest = (i == cnt - 1);
                    expected_words.push_back(e);
                end
                restart_msg();
            end
        endfunction

        // accepted digest word
        function void check_word(logic [31:0] dw, logic [2:0] idx, logic lst);
            t_digest_word e;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h idx %0d last %0b", dw, idx, lst);
                return;
            end
            e = expected_words.pop_front();
            if (e.digest_word !== dw || e.word_index !== idx || e.last_of_digest !== lst) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                             e.digest_word, e.word_index, e.last_of_digest, dw, idx, lst);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // [31:0] message_word, [34:32] valid_bytes
    logic        i_s_axis_tlast = 1'b0; // final_word
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [31:0] digest_word, [34:32] word_index
    logic        o_m_axis_tlast;        // last_of_digest
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    digest_scoreboard sb;
    bit quiet;
    bit hold_request;
    int items_sent;
    int idle_count;

    blake256_hash_engine dut (
        .i_clk, .i_rst_n,
        .i_s_axis_tvalid, .o_s_axis_tready, .i_s_axis_tdata, .i_s_axis_tlast,
        .o_m_axis_tvalid, .i_m_axis_tready, .o_m_axis_tdata, .o_m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 i_clk = ~i_clk;

    // output side ready with random stall bursts and one long hold-off
    initial begin
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    // digest word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(o_m_axis_tdata[31:0], o_m_axis_tdata[34:32], o_m_axis_tlast);
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // register write, called at a falling edge
    task automatic apb_write(t_reg_idx idx, logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(int'(idx) * 8);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] r, logic d224, logic [63:0] sh, logic [63:0] sl);
        apb_write(REG_ROUNDS, 64'(r));
        apb_write(REG_DIGEST_224, 64'(d224));
        apb_write(REG_SALT_HIGH, sh);
        apb_write(REG_SALT_LOW, sl);
    endtask

    // one message word, called and returning at a falling edge
    task automatic send_word(logic [31:0] word, logic [2:0] nb, logic fin);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, nb, word};
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_word(word, nb, fin);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int nwords, bit full_words);
        logic [2:0] nb;
        for (int i = 0; i < nwords; i++) begin
            nb = (full_words || $urandom_range(0, 7) != 0) ? 3'd4 : 3'($urandom_range(0, 7));
            send_word($urandom, nb, 1'b0);
        end
        nb = full_words ? 3'd4 : 3'($urandom_range(0, 7));
        send_word($urandom, nb, 1'b1);
    endtask

    // let the engine drain before touching the registers
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic random_phase(int budget, int max_words);
        int start;
        start = items_sent;
        while (items_sent - start < budget) send_message($urandom_range(0, max_words), 1'b0);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        quiet = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty message, extreme words, short and oversized counts
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_word(32'h0000_0000, 3'd3, 1'b1);
        send_word(32'hAABB_CCDD, 3'd2, 1'b0);
        send_word(32'h1122_3344, 3'd1, 1'b0);
        send_word(32'h5566_7788, 3'd7, 1'b1);
        // 56 bytes: padding spills into an extra block
        for (int i = 0; i < 13; i++) send_word($urandom, 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b1);

        // exact block multiple, 224 variant, all-ones salt, one round
        wait_idle();
        set_config(8'd1, 1'b1, '1, '1);
        send_message(15, 1'b1);
        send_word(32'h8000_0001, 3'd5, 1'b1);
        hold_request = 1'b1;
        random_phase(12, 20);

        // zero rounds selects fourteen
        wait_idle();
        set_config(8'd0, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(12, 20);

        // slowest setting, short messages only
        wait_idle();
        set_config(8'd255, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
        random_phase(6, 3);

        wait_idle();
        set_config(8'd2, 1'b1, {$urandom, $urandom}, 64'd0);
        random_phase(16, 24);

        // last part runs without idling
        wait_idle();
        set_config(8'($urandom_range(1, 8)), 1'b0, '0, '0);
        quiet = 1'b1;
        random_phase(16, 20);

        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/b256_pkg.sv
hw/rtl/b256_front.sv
hw/rtl/b256_fifo.sv
hw/rtl/b256_comp.sv
hw/rtl/b256_back.sv
hw/rtl/blake256_hash_engine.sv
hw/rtl/b256_chk.sv
dv/blake256_hash_engine_tb.sv
